[rtl/gdr_pkg.sv]
// ----------------------------------------------------------------------------
// gdr_pkg - shared types and constants of the grid dda raycast column unit
// map geometry, datapath widths, register indexes, divide ops, controller
// states and the command and status bundles between controller and datapath
// ----------------------------------------------------------------------------
package gdr_pkg;

    // map geometry
    localparam int MAP_WIDTH  = 64;
    localparam int MAP_HEIGHT = 64;
    localparam int MAP_CELLS  = MAP_WIDTH * MAP_HEIGHT;
    localparam int MAP_AW     = $clog2(MAP_CELLS);
    localparam int CLR_W      = MAP_AW + 1;
    localparam int COORD_W    = $clog2(MAP_WIDTH + MAP_HEIGHT) + 2;

    // divider widths
    localparam int DIVN_W = 48;
    localparam int DIVD_W = 33;
    localparam int DCNT_W = $clog2(DIVN_W);

    // fixed point limits
    localparam logic [23:0] PERP_MAX = 24'hFFFFFF;
    localparam logic [14:0] LH_MAX   = 15'h7FFF;

    // configuration register indexes
    localparam logic [2:0] REG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] REG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] REG_POS_X         = 3'd2;
    localparam logic [2:0] REG_POS_Y         = 3'd3;
    localparam logic [2:0] REG_DIR_X         = 3'd4;
    localparam logic [2:0] REG_DIR_Y         = 3'd5;
    localparam logic [2:0] REG_PLANE_X       = 3'd6;
    localparam logic [2:0] REG_PLANE_Y       = 3'd7;

    // operation run on the shared divider
    typedef enum logic [2:0] {
        OP_CAM,
        OP_DX,
        OP_DY,
        OP_PERP,
        OP_LH,
        OP_T0,
        OP_T1
    } div_op_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_RAY_MUL,
        S_RAY_ADD,
        S_SIDE_MUL,
        S_STEP,
        S_CHECK,
        S_T_MUL,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic    accept;
        logic    clr_step;
        logic    div_start;
        logic    div_capture;
        div_op_t op;
        logic    ray_mul;
        logic    ray_add;
        logic    side_mul;
        logic    step;
        logic    t_mul;
        logic    load_out;
    } gdr_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic div_done;
        logic escape_now;
        logic wall_hit;
        logic out_free;
    } gdr_sts_t;

endpackage

[rtl/gdr_div.sv]
// ----------------------------------------------------------------------------
// gdr_div - shared restoring divider
// unsigned quotient, one bit per cycle, done pulses after the last bit
// ----------------------------------------------------------------------------
module gdr_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [gdr_pkg::DIVN_W-1:0]       dividend,
    input  logic [gdr_pkg::DIVD_W-1:0]       divisor,
    output logic                             done,
    output logic [gdr_pkg::DIVN_W-1:0]       quotient
);

    logic [gdr_pkg::DIVN_W-1:0] quo_reg;
    logic [gdr_pkg::DIVD_W-1:0] rem_reg;
    logic [gdr_pkg::DIVD_W-1:0] dvs_reg;
    logic [gdr_pkg::DCNT_W-1:0] cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [gdr_pkg::DIVD_W:0]   rem_sh;
    logic [gdr_pkg::DIVD_W:0]   diff;
    logic                       ge;
    logic [gdr_pkg::DIVD_W-1:0] rem_next;

    // one trial subtract per cycle
    assign rem_sh   = {rem_reg, quo_reg[gdr_pkg::DIVN_W-1]};
    assign diff     = rem_sh - {1'b0, dvs_reg};
    assign ge       = rem_sh >= {1'b0, dvs_reg};
    assign rem_next = ge ? diff[gdr_pkg::DIVD_W-1:0] : rem_sh[gdr_pkg::DIVD_W-1:0];

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == gdr_pkg::DCNT_W'(gdr_pkg::DIVN_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // operands
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[gdr_pkg::DIVN_W-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/gdr_datapath.sv]
// ----------------------------------------------------------------------------
// gdr_datapath - registers, wall map, walk and result arithmetic
// holds the camera registers, the wall map memory with its clearing counter,
// the ray and step distance registers, the shared divider and the result item
// ----------------------------------------------------------------------------
module gdr_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  gdr_pkg::gdr_cmd_t   cmd,
    output gdr_pkg::gdr_sts_t   sts,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [21:0]         cfg_data,
    input  logic                action,
    input  logic [5:0]          cell_row,
    input  logic [5:0]          cell_col,
    input  logic                cell_wall,
    input  logic [11:0]         column,
    input  logic signed [13:0]  pitch,
    input  logic signed [15:0]  eye_offset,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [11:0]         out_column,
    output logic                side,
    output logic [5:0]          hit_col,
    output logic [5:0]          hit_row,
    output logic [23:0]         perp_dist,
    output logic [14:0]         line_height,
    output logic [14:0]         draw_start,
    output logic signed [15:0]  draw_end,
    output logic                escaped
);

    localparam int CW = gdr_pkg::COORD_W;

    // configuration registers
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [21:0] pos_x_reg;
    logic [21:0] pos_y_reg;
    logic [18:0] dir_x_reg;
    logic [18:0] dir_y_reg;
    logic [18:0] plane_x_reg;
    logic [18:0] plane_y_reg;

    // latched item
    logic [11:0] column_reg;
    logic [13:0] pitch_reg;
    logic [15:0] eye_reg;

    // ray state
    logic signed [31:0] cam_reg;
    logic signed [50:0] prod_x_reg;
    logic signed [50:0] prod_y_reg;
    logic signed [33:0] rx_reg;
    logic signed [33:0] ry_reg;
    logic [32:0]        dx_reg;
    logic [32:0]        dy_reg;
    logic [40:0]        sdx_reg;
    logic [40:0]        sdy_reg;
    logic signed [CW-1:0] mx_reg;
    logic signed [CW-1:0] my_reg;
    logic               side_reg;
    logic               esc_reg;
    logic [23:0]        perp_reg;
    logic [14:0]        lh_reg;
    logic signed [42:0] n0_reg;
    logic signed [42:0] n1_reg;
    logic [14:0]        t0_reg;
    logic [15:0]        t1_reg;

    // wall map
    logic                       mem [0:gdr_pkg::MAP_CELLS-1];
    logic                       rd_reg;
    logic [gdr_pkg::CLR_W-1:0]  clr_cnt_reg;
    logic                       clr_done;
    logic                       wr_en;
    logic [gdr_pkg::MAP_AW-1:0] wr_addr;
    logic                       wr_data;
    logic [gdr_pkg::MAP_AW-1:0] rd_addr;

    // result item
    logic        out_valid_reg;
    logic [11:0] o_column_reg;
    logic        o_side_reg;
    logic [5:0]  o_col_reg;
    logic [5:0]  o_row_reg;
    logic [23:0] o_perp_reg;
    logic [14:0] o_lh_reg;
    logic [14:0] o_start_reg;
    logic [15:0] o_end_reg;
    logic        o_esc_reg;

    // combinational terms
    logic [12:0]         w_eff;
    logic [12:0]         h_eff;
    logic signed [50:0]  adj_x;
    logic signed [50:0]  adj_y;
    logic signed [50:0]  tr_x;
    logic signed [50:0]  tr_y;
    logic [33:0]         rx_neg;
    logic [33:0]         ry_neg;
    logic [32:0]         rx_mag;
    logic [32:0]         ry_mag;
    logic                rx_zero;
    logic                ry_zero;
    logic [16:0]         frac_x;
    logic [16:0]         frac_y;
    logic [49:0]         psx;
    logic [49:0]         psy;
    logic                step_x;
    logic signed [CW-1:0] sx_inc;
    logic signed [CW-1:0] sy_inc;
    logic signed [CW-1:0] nmx;
    logic signed [CW-1:0] nmy;
    logic                out_map;
    logic [5:0]          hit_cell;
    logic [21:0]         hit_pos;
    logic                den_neg;
    logic                den_zero;
    logic [32:0]         den_mag;
    logic [24:0]         num;
    logic [24:0]         num_neg;
    logic [23:0]         num_mag;
    logic [16:0]         base;
    logic [16:0]         a0;
    logic [16:0]         a1;
    logic [42:0]         n0_neg;
    logic [42:0]         n1_neg;
    logic [41:0]         n0_mag;
    logic [41:0]         n1_mag;
    logic [gdr_pkg::DIVN_W-1:0] div_n;
    logic [gdr_pkg::DIVD_W-1:0] div_d;
    logic [gdr_pkg::DIVN_W-1:0] div_q;
    logic                div_done;
    logic [15:0]         q_neg16;

    assign w_eff = (width_reg == 13'd0) ? 13'd1 : width_reg;
    assign h_eff = (height_reg == 13'd0) ? 13'd1 : height_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= 13'd640;
            height_reg  <= 13'd480;
            pos_x_reg   <= 22'd0;
            pos_y_reg   <= 22'd0;
            dir_x_reg   <= 19'd65536;
            dir_y_reg   <= 19'd0;
            plane_x_reg <= 19'd0;
            plane_y_reg <= 19'd43254;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gdr_pkg::REG_SCREEN_WIDTH:  width_reg   <= cfg_data[12:0];
                gdr_pkg::REG_SCREEN_HEIGHT: height_reg  <= cfg_data[12:0];
                gdr_pkg::REG_POS_X:         pos_x_reg   <= cfg_data;
                gdr_pkg::REG_POS_Y:         pos_y_reg   <= cfg_data;
                gdr_pkg::REG_DIR_X:         dir_x_reg   <= cfg_data[18:0];
                gdr_pkg::REG_DIR_Y:         dir_y_reg   <= cfg_data[18:0];
                gdr_pkg::REG_PLANE_X:       plane_x_reg <= cfg_data[18:0];
                gdr_pkg::REG_PLANE_Y:       plane_y_reg <= cfg_data[18:0];
                default:                    width_reg   <= width_reg;
            endcase
        end
    end

    // clearing counter, runs once after reset
    assign clr_done = clr_cnt_reg == gdr_pkg::CLR_W'(gdr_pkg::MAP_CELLS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step && !clr_done)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // map write port: clearing pass or cell write item
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_cnt_reg[gdr_pkg::MAP_AW-1:0];
        wr_data = 1'b0;
        if (cmd.clr_step && !clr_done)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.accept && !action && (int'(cell_row) < gdr_pkg::MAP_HEIGHT)
                 && (int'(cell_col) < gdr_pkg::MAP_WIDTH))
        begin
            wr_en   = 1'b1;
            wr_addr = gdr_pkg::MAP_AW'(int'(cell_row) * gdr_pkg::MAP_WIDTH + int'(cell_col));
            wr_data = cell_wall;
        end
    end

    assign rd_addr = gdr_pkg::MAP_AW'(int'(nmy) * gdr_pkg::MAP_WIDTH + int'(nmx));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[rd_addr];
    end

    // ray magnitudes and signs
    assign adj_x   = prod_x_reg + (prod_x_reg[50] ? 51'sd65535 : 51'sd0);
    assign adj_y   = prod_y_reg + (prod_y_reg[50] ? 51'sd65535 : 51'sd0);
    assign tr_x    = adj_x >>> 16;
    assign tr_y    = adj_y >>> 16;
    assign rx_neg  = -rx_reg;
    assign ry_neg  = -ry_reg;
    assign rx_mag  = rx_reg[33] ? rx_neg[32:0] : rx_reg[32:0];
    assign ry_mag  = ry_reg[33] ? ry_neg[32:0] : ry_reg[32:0];
    assign rx_zero = rx_reg == 34'sd0;
    assign ry_zero = ry_reg == 34'sd0;

    // initial side distances
    assign frac_x = rx_reg[33] ? {1'b0, pos_x_reg[15:0]} : 17'h10000 - {1'b0, pos_x_reg[15:0]};
    assign frac_y = ry_reg[33] ? {1'b0, pos_y_reg[15:0]} : 17'h10000 - {1'b0, pos_y_reg[15:0]};
    assign psx    = 50'(frac_x) * 50'(dx_reg);
    assign psy    = 50'(frac_y) * 50'(dy_reg);

    // one dda step, ties step y
    assign step_x  = sdx_reg < sdy_reg;
    assign sx_inc  = rx_reg[33] ? {CW{1'b1}} : CW'(1);
    assign sy_inc  = ry_reg[33] ? {CW{1'b1}} : CW'(1);
    assign nmx     = step_x ? mx_reg + sx_inc : mx_reg;
    assign nmy     = step_x ? my_reg : my_reg + sy_inc;
    assign out_map = (nmx < $signed(CW'(0))) || (nmx >= $signed(CW'(gdr_pkg::MAP_WIDTH)))
                  || (nmy < $signed(CW'(0))) || (nmy >= $signed(CW'(gdr_pkg::MAP_HEIGHT)));

    // perpendicular distance numerator on the side stepped
    assign hit_cell = side_reg ? my_reg[5:0] : mx_reg[5:0];
    assign hit_pos  = side_reg ? pos_y_reg : pos_x_reg;
    assign den_neg  = side_reg ? ry_reg[33] : rx_reg[33];
    assign den_zero = side_reg ? ry_zero : rx_zero;
    assign den_mag  = side_reg ? ry_mag : rx_mag;
    assign num      = 25'({hit_cell, 16'b0}) - 25'(hit_pos) + (den_neg ? 25'd65536 : 25'd0);
    assign num_neg  = -num;
    assign num_mag  = num[24] ? num_neg[23:0] : num[23:0];

    // row terms
    assign base   = 17'(h_eff >> 1) + {{3{pitch_reg[13]}}, pitch_reg};
    assign a0     = base - 17'(lh_reg >> 1);
    assign a1     = base + 17'(lh_reg >> 1);
    assign n0_neg = -n0_reg;
    assign n1_neg = -n1_reg;
    assign n0_mag = n0_reg[42] ? n0_neg[41:0] : n0_reg[41:0];
    assign n1_mag = n1_reg[42] ? n1_neg[41:0] : n1_reg[41:0];

    // divider operand select
    always_comb
    begin
        div_n = '0;
        div_d = '0;
        case (cmd.op)
            gdr_pkg::OP_CAM:
            begin
                div_n = gdr_pkg::DIVN_W'({column_reg, 17'b0});
                div_d = gdr_pkg::DIVD_W'(w_eff);
            end
            gdr_pkg::OP_DX:
            begin
                div_n = gdr_pkg::DIVN_W'(33'h1_0000_0000);
                div_d = rx_mag;
            end
            gdr_pkg::OP_DY:
            begin
                div_n = gdr_pkg::DIVN_W'(33'h1_0000_0000);
                div_d = ry_mag;
            end
            gdr_pkg::OP_PERP:
            begin
                div_n = gdr_pkg::DIVN_W'({num_mag, 16'b0});
                div_d = den_mag;
            end
            gdr_pkg::OP_LH:
            begin
                div_n = gdr_pkg::DIVN_W'({h_eff, 16'b0});
                div_d = gdr_pkg::DIVD_W'(perp_reg);
            end
            gdr_pkg::OP_T0:
            begin
                div_n = gdr_pkg::DIVN_W'(n0_mag);
                div_d = gdr_pkg::DIVD_W'(perp_reg);
            end
            gdr_pkg::OP_T1:
            begin
                div_n = gdr_pkg::DIVN_W'(n1_mag);
                div_d = gdr_pkg::DIVD_W'(perp_reg);
            end
            default:
            begin
                div_n = '0;
                div_d = '0;
            end
        endcase
    end

    gdr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    assign q_neg16 = -div_q[15:0];

    // ray, walk and result arithmetic
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            column_reg <= column;
            pitch_reg  <= pitch;
            eye_reg    <= eye_offset;
            esc_reg    <= 1'b0;
        end
        if (cmd.ray_mul)
        begin
            prod_x_reg <= $signed(plane_x_reg) * cam_reg;
            prod_y_reg <= $signed(plane_y_reg) * cam_reg;
        end
        if (cmd.ray_add)
        begin
            rx_reg <= $signed({{15{dir_x_reg[18]}}, dir_x_reg}) + $signed(tr_x[33:0]);
            ry_reg <= $signed({{15{dir_y_reg[18]}}, dir_y_reg}) + $signed(tr_y[33:0]);
            mx_reg <= $signed(CW'(pos_x_reg[21:16]));
            my_reg <= $signed(CW'(pos_y_reg[21:16]));
        end
        if (cmd.side_mul)
        begin
            sdx_reg <= 41'(psx[49:16]);
            sdy_reg <= 41'(psy[49:16]);
        end
        if (cmd.step)
        begin
            esc_reg <= out_map;
            if (step_x)
            begin
                sdx_reg  <= sdx_reg + 41'(dx_reg);
                mx_reg   <= nmx;
                side_reg <= 1'b0;
            end
            else
            begin
                sdy_reg  <= sdy_reg + 41'(dy_reg);
                my_reg   <= nmy;
                side_reg <= 1'b1;
            end
        end
        if (cmd.t_mul)
        begin
            n0_reg <= $signed(a0) * $signed({1'b0, perp_reg}) + $signed({eye_reg, 16'b0});
            n1_reg <= $signed(a1) * $signed({1'b0, perp_reg}) + $signed({eye_reg, 16'b0});
        end
        if (cmd.div_capture)
        begin
            case (cmd.op)
                gdr_pkg::OP_CAM:
                begin
                    cam_reg <= $signed({1'b0, div_q[30:0]}) - 32'sd65536;
                end
                gdr_pkg::OP_DX:
                begin
                    dx_reg <= ry_zero ? 33'd0 : (rx_zero ? 33'h10000 : div_q[32:0]);
                end
                gdr_pkg::OP_DY:
                begin
                    dy_reg <= rx_zero ? 33'd0 : (ry_zero ? 33'h10000 : div_q[32:0]);
                end
                gdr_pkg::OP_PERP:
                begin
                    if (den_zero)
                        perp_reg <= gdr_pkg::PERP_MAX;
                    else if ((num[24] ^ den_neg) || (div_q == '0))
                        perp_reg <= 24'd1;
                    else if (|div_q[gdr_pkg::DIVN_W-1:24])
                        perp_reg <= gdr_pkg::PERP_MAX;
                    else
                        perp_reg <= div_q[23:0];
                end
                gdr_pkg::OP_LH:
                begin
                    lh_reg <= (|div_q[gdr_pkg::DIVN_W-1:15]) ? gdr_pkg::LH_MAX : div_q[14:0];
                end
                gdr_pkg::OP_T0:
                begin
                    if (n0_reg[42])
                        t0_reg <= 15'd0;
                    else if (|div_q[gdr_pkg::DIVN_W-1:15])
                        t0_reg <= gdr_pkg::LH_MAX;
                    else
                        t0_reg <= div_q[14:0];
                end
                gdr_pkg::OP_T1:
                begin
                    if (n1_reg[42])
                        t1_reg <= (div_q > gdr_pkg::DIVN_W'(32768)) ? 16'h8000 : q_neg16;
                    else if (div_q >= gdr_pkg::DIVN_W'(h_eff))
                        t1_reg <= 16'(h_eff - 13'd1);
                    else
                        t1_reg <= div_q[15:0];
                end
                default:
                begin
                    cam_reg <= cam_reg;
                end
            endcase
        end
    end

    // result item register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            o_column_reg <= column_reg;
            o_esc_reg    <= esc_reg;
            if (esc_reg)
            begin
                o_side_reg  <= 1'b0;
                o_col_reg   <= 6'd0;
                o_row_reg   <= 6'd0;
                o_perp_reg  <= 24'd0;
                o_lh_reg    <= 15'd0;
                o_start_reg <= 15'd0;
                o_end_reg   <= 16'd0;
            end
            else
            begin
                o_side_reg  <= side_reg;
                o_col_reg   <= mx_reg[5:0];
                o_row_reg   <= my_reg[5:0];
                o_perp_reg  <= perp_reg;
                o_lh_reg    <= lh_reg;
                o_start_reg <= t0_reg;
                o_end_reg   <= t1_reg;
            end
        end
    end

    // status
    assign sts.clr_done   = clr_done;
    assign sts.div_done   = div_done;
    assign sts.escape_now = out_map;
    assign sts.wall_hit   = rd_reg;
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_column  = o_column_reg;
    assign side        = o_side_reg;
    assign hit_col     = o_col_reg;
    assign hit_row     = o_row_reg;
    assign perp_dist   = o_perp_reg;
    assign line_height = o_lh_reg;
    assign draw_start  = o_start_reg;
    assign draw_end    = o_end_reg;
    assign escaped     = o_esc_reg;

`ifndef SYNTHESIS
    // a captured distance is never zero
    a_perp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_capture && cmd.op == gdr_pkg::OP_PERP) |=> (perp_reg != 24'd0))
        else $error("perpendicular distance captured as zero");

    // draw end never passes the last screen row
    a_end_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.div_capture && cmd.op == gdr_pkg::OP_T1)
        |=> ($signed(t1_reg) < $signed({4'b0, h_eff})))
        else $error("draw end beyond screen height");

    // the walk never runs during the clearing pass
    a_walk_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step || cmd.accept) |-> clr_done)
        else $error("map used before clearing finished");

    // a waiting result item is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result item overwritten");
`endif

endmodule

[rtl/gdr_ctrl.sv]
// ----------------------------------------------------------------------------
// gdr_ctrl - sequencer of the raycast column unit
// runs the clearing pass, takes items, sequences the divides, the dda walk
// and the result hand-off
// ----------------------------------------------------------------------------
module gdr_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               action,
    output logic               in_ready,
    input  gdr_pkg::gdr_sts_t  sts,
    output gdr_pkg::gdr_cmd_t  cmd
);

    gdr_pkg::ctrl_state_t state_reg, state_next;
    gdr_pkg::div_op_t     op_reg, op_next;

    // state and op registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gdr_pkg::S_CLEAR;
            op_reg    <= gdr_pkg::OP_CAM;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        unique case (state_reg)
            gdr_pkg::S_CLEAR:
            begin
                if (sts.clr_done)
                    state_next = gdr_pkg::S_IDLE;
            end
            gdr_pkg::S_IDLE:
            begin
                if (in_valid && action)
                begin
                    state_next = gdr_pkg::S_DIV_GO;
                    op_next    = gdr_pkg::OP_CAM;
                end
            end
            gdr_pkg::S_DIV_GO:
            begin
                state_next = gdr_pkg::S_DIV_WAIT;
            end
            gdr_pkg::S_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    case (op_reg)
                        gdr_pkg::OP_CAM:  state_next = gdr_pkg::S_RAY_MUL;
                        gdr_pkg::OP_DX:
                        begin
                            state_next = gdr_pkg::S_DIV_GO;
                            op_next    = gdr_pkg::OP_DY;
                        end
                        gdr_pkg::OP_DY:   state_next = gdr_pkg::S_SIDE_MUL;
                        gdr_pkg::OP_PERP:
                        begin
                            state_next = gdr_pkg::S_DIV_GO;
                            op_next    = gdr_pkg::OP_LH;
                        end
                        gdr_pkg::OP_LH:   state_next = gdr_pkg::S_T_MUL;
                        gdr_pkg::OP_T0:
                        begin
                            state_next = gdr_pkg::S_DIV_GO;
                            op_next    = gdr_pkg::OP_T1;
                        end
                        gdr_pkg::OP_T1:   state_next = gdr_pkg::S_DONE;
                        default:          state_next = gdr_pkg::S_IDLE;
                    endcase
                end
            end
            gdr_pkg::S_RAY_MUL:
            begin
                state_next = gdr_pkg::S_RAY_ADD;
            end
            gdr_pkg::S_RAY_ADD:
            begin
                state_next = gdr_pkg::S_DIV_GO;
                op_next    = gdr_pkg::OP_DX;
            end
            gdr_pkg::S_SIDE_MUL:
            begin
                state_next = gdr_pkg::S_STEP;
            end
            gdr_pkg::S_STEP:
            begin
                state_next = sts.escape_now ? gdr_pkg::S_DONE : gdr_pkg::S_CHECK;
            end
            gdr_pkg::S_CHECK:
            begin
                if (sts.wall_hit)
                begin
                    state_next = gdr_pkg::S_DIV_GO;
                    op_next    = gdr_pkg::OP_PERP;
                end
                else
                begin
                    state_next = gdr_pkg::S_STEP;
                end
            end
            gdr_pkg::S_T_MUL:
            begin
                state_next = gdr_pkg::S_DIV_GO;
                op_next    = gdr_pkg::OP_T0;
            end
            gdr_pkg::S_DONE:
            begin
                if (sts.out_free)
                    state_next = gdr_pkg::S_IDLE;
            end
            default:
            begin
                state_next = gdr_pkg::S_IDLE;
            end
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd      = '0;
        cmd.op   = op_reg;
        in_ready = 1'b0;
        unique case (state_reg)
            gdr_pkg::S_CLEAR:    cmd.clr_step = 1'b1;
            gdr_pkg::S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            gdr_pkg::S_DIV_GO:   cmd.div_start   = 1'b1;
            gdr_pkg::S_DIV_WAIT: cmd.div_capture = sts.div_done;
            gdr_pkg::S_RAY_MUL:  cmd.ray_mul     = 1'b1;
            gdr_pkg::S_RAY_ADD:  cmd.ray_add     = 1'b1;
            gdr_pkg::S_SIDE_MUL: cmd.side_mul    = 1'b1;
            gdr_pkg::S_STEP:     cmd.step        = 1'b1;
            gdr_pkg::S_CHECK:    cmd.step        = 1'b0;
            gdr_pkg::S_T_MUL:    cmd.t_mul       = 1'b1;
            gdr_pkg::S_DONE:     cmd.load_out    = sts.out_free;
            default:             cmd.step        = 1'b0;
        endcase
    end

endmodule

[rtl/grid_dda_raycast_column_unit.sv]
// ----------------------------------------------------------------------------
// grid_dda_raycast_column_unit - one-column dda raycaster over a wall map
// writes wall cells and casts one screen column per item, giving side, cell,
// perpendicular distance, line height and clamped draw rows per cast
//
//   channel  handshake               payload
//   cfg      cfg_we                  cfg_index, cfg_data
//   in       in_valid / in_ready     action, cell_row, cell_col, cell_wall,
//                                    column, pitch, eye_offset
//   out      out_valid / out_ready   out_column .. escaped, one item per cast
//
// a cell write is done as the item is taken; a cast runs 3 divides, 7 on a hit, on the
// one-bit-per-cycle divider, plus a step state and a check state per dda step
// after reset a clearing pass writes the 4096 map cells, one a cycle, and no
// item is taken until it ends
// a new item is taken while a finished result waits; a cast only stalls at
// its end if the previous result has not been taken
// ----------------------------------------------------------------------------
module grid_dda_raycast_column_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [21:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  logic [5:0]         cell_row,
    input  logic [5:0]         cell_col,
    input  logic               cell_wall,
    input  logic [11:0]        column,
    input  logic signed [13:0] pitch,
    input  logic signed [15:0] eye_offset,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [11:0]        out_column,
    output logic               side,
    output logic [5:0]         hit_col,
    output logic [5:0]         hit_row,
    output logic [23:0]        perp_dist,
    output logic [14:0]        line_height,
    output logic [14:0]        draw_start,
    output logic signed [15:0] draw_end,
    output logic               escaped
);

    gdr_pkg::gdr_cmd_t cmd;
    gdr_pkg::gdr_sts_t sts;

    // sequencer
    gdr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath
    gdr_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .action      (action),
        .cell_row    (cell_row),
        .cell_col    (cell_col),
        .cell_wall   (cell_wall),
        .column      (column),
        .pitch       (pitch),
        .eye_offset  (eye_offset),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_column  (out_column),
        .side        (side),
        .hit_col     (hit_col),
        .hit_row     (hit_row),
        .perp_dist   (perp_dist),
        .line_height (line_height),
        .draw_start  (draw_start),
        .draw_end    (draw_end),
        .escaped     (escaped)
    );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench of the grid dda raycast column unit
// drives map writes and column casts over the valid/ready input, rewrites the
// camera registers between phases and checks every cast result field by field
// against a behavioral raycaster kept in step with the wall map and registers
// ----------------------------------------------------------------------------
module tb_top;

    localparam int ONE = 65536;

    // one input item
    typedef struct {
        bit        act;
        bit [5:0]  row;
        bit [5:0]  col;
        bit        wall;
        bit [11:0] scol;
        bit [13:0] pit;
        bit [15:0] eye;
        bit        sure_escape;
    } ray_item_t;

    // one cast result
    typedef struct packed {
        logic [11:0]        column;
        logic               side;
        logic [5:0]         hcol;
        logic [5:0]         hrow;
        logic [23:0]        perp;
        logic [14:0]        lh;
        logic [14:0]        dstart;
        logic signed [15:0] dend;
        logic               esc;
    } ray_result_t;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               cfg_we = 0;
    logic [2:0]         cfg_index = '0;
    logic [21:0]        cfg_data = '0;
    logic               in_valid = 0;
    logic               in_ready;
    logic               action = 0;
    logic [5:0]         cell_row = '0;
    logic [5:0]         cell_col = '0;
    logic               cell_wall = 0;
    logic [11:0]        column = '0;
    logic signed [13:0] pitch = '0;
    logic signed [15:0] eye_offset = '0;
    logic               out_valid;
    logic               out_ready = 0;
    logic [11:0]        out_column;
    logic               side;
    logic [5:0]         hit_col;
    logic [5:0]         hit_row;
    logic [23:0]        perp_dist;
    logic [14:0]        line_height;
    logic [14:0]        draw_start;
    logic signed [15:0] draw_end;
    logic               escaped;

    grid_dda_raycast_column_unit dut (.*);

    // bench state
    bit [21:0]   cam_regs [8];
    bit          wall_map [gdr_pkg::MAP_CELLS];
    ray_result_t pending_rays [$];
    ray_item_t   directed_rows [$];
    int          send_idle = 0;
    int          recv_idle = 0;
    bit          hold_req = 0;
    int          errors = 0;

    // clock
    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    // behavioral raycaster over the shadow map and registers
    function automatic ray_result_t cast_ray(bit [11:0] scol, bit [13:0] pit, bit [15:0] eo);
        longint w, h, px, py, rx, ry, cam, dx, dy, sdx, sdy, mx, my, sx, sy;
        longint perp, num, den, lh, base, t0, t1;
        bit sd, esc;
        ray_result_t r;
        r = '0;
        sd = 0;
        esc = 0;
        w = longint'(cam_regs[gdr_pkg::REG_SCREEN_WIDTH][12:0]);
        if (w == 0) w = 1;
        h = longint'(cam_regs[gdr_pkg::REG_SCREEN_HEIGHT][12:0]);
        if (h == 0) h = 1;
        px = longint'(cam_regs[gdr_pkg::REG_POS_X]);
        py = longint'(cam_regs[gdr_pkg::REG_POS_Y]);
        cam = (longint'(scol) * 2 * ONE) / w - ONE;
        rx = longint'($signed(cam_regs[gdr_pkg::REG_DIR_X][18:0]))
             + (longint'($signed(cam_regs[gdr_pkg::REG_PLANE_X][18:0])) * cam) / ONE;
        ry = longint'($signed(cam_regs[gdr_pkg::REG_DIR_Y][18:0]))
             + (longint'($signed(cam_regs[gdr_pkg::REG_PLANE_Y][18:0])) * cam) / ONE;
        mx = px >>> 16;
        my = py >>> 16;
        // reciprocal step lengths with the zero-direction rules
        if (ry == 0) dx = 0;
        else if (rx == 0) dx = ONE;
        else dx = (longint'(1) <<< 32) / (rx < 0 ? -rx : rx);
        if (rx == 0) dy = 0;
        else if (ry == 0) dy = ONE;
        else dy = (longint'(1) <<< 32) / (ry < 0 ? -ry : ry);
        if (rx < 0) begin sx = -1; sdx = ((px - mx * ONE) * dx) >>> 16; end
        else begin sx = 1; sdx = ((mx * ONE + ONE - px) * dx) >>> 16; end
        if (ry < 0) begin sy = -1; sdy = ((py - my * ONE) * dy) >>> 16; end
        else begin sy = 1; sdy = ((my * ONE + ONE - py) * dy) >>> 16; end
        // grid walk, ties step y, start cell never tested
        while (1)
        begin
            if (sdx < sdy) begin sdx += dx; mx += sx; sd = 0; end
            else begin sdy += dy; my += sy; sd = 1; end
            if (mx < 0 || mx >= gdr_pkg::MAP_WIDTH || my < 0 || my >= gdr_pkg::MAP_HEIGHT)
            begin
                esc = 1;
                break;
            end
            if (wall_map[my * gdr_pkg::MAP_WIDTH + mx]) break;
        end
        r.column = scol;
        if (esc)
        begin
            r.esc = 1;
            return r;
        end
        // distance, slice height and draw rows
        if (sd == 0) begin num = mx * ONE - px + (sx < 0 ? ONE : 0); den = rx; end
        else begin num = my * ONE - py + (sy < 0 ? ONE : 0); den = ry; end
        perp = (den == 0) ? longint'(gdr_pkg::PERP_MAX) : (num * ONE) / den;
        if (perp < 1) perp = 1;
        if (perp > longint'(gdr_pkg::PERP_MAX)) perp = longint'(gdr_pkg::PERP_MAX);
        lh = (h * ONE) / perp;
        if (lh > longint'(gdr_pkg::LH_MAX)) lh = longint'(gdr_pkg::LH_MAX);
        base = h / 2 + longint'($signed(pit));
        t0 = ((base - lh / 2) * perp + longint'($signed(eo)) * ONE) / perp;
        t1 = ((base + lh / 2) * perp + longint'($signed(eo)) * ONE) / perp;
        if (t0 < 0) t0 = 0;
        if (t0 > longint'(gdr_pkg::LH_MAX)) t0 = longint'(gdr_pkg::LH_MAX);
        if (t1 >= h) t1 = h - 1;
        if (t1 < -32768) t1 = -32768;
        r.side   = sd;
        r.hcol   = mx[5:0];
        r.hrow   = my[5:0];
        r.perp   = perp[23:0];
        r.lh     = lh[14:0];
        r.dstart = t0[14:0];
        r.dend   = t1[15:0];
        return r;
    endfunction

    // register write, only while the block is idle
    task automatic set_reg(logic [2:0] idx, bit [21:0] val);
        int unsigned bits [8] = '{13, 13, 22, 22, 19, 19, 19, 19};
        @(negedge clk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 0;
        cam_regs[idx] = val & ((22'h1 << bits[idx]) - 1);
    endtask

    task automatic set_camera(int w, int h, int px, int py, int dx, int dy, int plx, int ply);
        set_reg(gdr_pkg::REG_SCREEN_WIDTH, 22'(w));
        set_reg(gdr_pkg::REG_SCREEN_HEIGHT, 22'(h));
        set_reg(gdr_pkg::REG_POS_X, 22'(px));
        set_reg(gdr_pkg::REG_POS_Y, 22'(py));
        set_reg(gdr_pkg::REG_DIR_X, 22'(dx));
        set_reg(gdr_pkg::REG_DIR_Y, 22'(dy));
        set_reg(gdr_pkg::REG_PLANE_X, 22'(plx));
        set_reg(gdr_pkg::REG_PLANE_Y, 22'(ply));
    endtask

    // offer one item, update the shadow state when it is taken
    task automatic send_item(ray_item_t it);
        ray_result_t r;
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid   <= 1;
        action     <= it.act;
        cell_row   <= it.row;
        cell_col   <= it.col;
        cell_wall  <= it.wall;
        column     <= it.scol;
        pitch      <= it.pit;
        eye_offset <= it.eye;
        do @(posedge clk); while (!in_ready);
        if (!it.act)
            wall_map[it.row * gdr_pkg::MAP_WIDTH + it.col] = it.wall;
        else if (it.sure_escape)
        begin
            r = '0;
            r.column = it.scol;
            r.esc = 1;
            pending_rays.push_back(r);
        end
        else
            pending_rays.push_back(cast_ray(it.scol, it.pit, it.eye));
    endtask

    task automatic end_burst();
        @(negedge clk);
        in_valid <= 0;
        wait (pending_rays.size() == 0);
        repeat (50) @(posedge clk);
    endtask

    function automatic ray_item_t random_item();
        ray_item_t it;
        int w;
        w = int'(cam_regs[gdr_pkg::REG_SCREEN_WIDTH][12:0]);
        it.act  = ($urandom_range(0, 99) < 65);
        it.row  = 6'($urandom_range(0, 63));
        it.col  = 6'($urandom_range(0, 63));
        it.wall = ($urandom_range(0, 99) < 60);
        // mostly columns on screen, some past its edge
        if (w > 0 && $urandom_range(0, 9) != 0)
            it.scol = 12'($urandom_range(0, w > 4096 ? 4095 : w - 1));
        else
            it.scol = 12'($urandom_range(0, 4095));
        it.pit  = 14'($urandom_range(0, 16383));
        it.eye  = 16'($urandom_range(0, 65535));
        it.sure_escape = 0;
        return it;
    endfunction

    task automatic add_row(int act, int row, int col, int wall, int scol, int pit, int eye,
                           int sure_esc);
        ray_item_t it;
        it.act = 1'(act); it.row = 6'(row); it.col = 6'(col); it.wall = 1'(wall);
        it.scol = 12'(scol); it.pit = 14'(pit); it.eye = 16'(eye);
        it.sure_escape = 1'(sure_esc);
        directed_rows.push_back(it);
    endtask

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        ray_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_rays.size() == 0)
            begin
                $display("%0t ns: unexpected result, expected none, got column %0d",
                         $time, out_column);
                errors++;
            end
            else
            begin
                e = pending_rays.pop_front();
                check_field("out_column", e.column, out_column);
                check_field("side", e.side, side);
                check_field("hit_col", e.hcol, hit_col);
                check_field("hit_row", e.hrow, hit_row);
                check_field("perp_dist", e.perp, perp_dist);
                check_field("line_height", e.lh, line_height);
                check_field("draw_start", e.dstart, draw_start);
                check_field("draw_end", e.dend, draw_end);
                check_field("escaped", e.esc, escaped);
            end
        end
    end

    // receiver, with a long hold-off on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 0;
                repeat (3000) @(negedge clk);
                hold_req = 0;
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // stimulus
    initial
    begin
        cam_regs = '{22'd640, 22'd480, 22'd0, 22'd0, 22'd65536, 22'd0, 22'd0, 22'd43254};
        foreach (wall_map[i]) wall_map[i] = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;

        // directed: empty map first, then walls around the start cell
        add_row(1, 0, 0, 0, 0, 0, 0, 1);
        add_row(1, 0, 0, 0, 4095, 8191, 32767, 1);
        add_row(0, 0, 5, 1, 0, 0, 0, 0);
        add_row(0, 63, 63, 1, 0, 0, 0, 0);
        add_row(0, 0, 0, 1, 0, 0, 0, 0);
        add_row(0, 2, 3, 1, 0, 0, 0, 0);
        add_row(1, 0, 0, 0, 320, 0, 0, 0);
        add_row(1, 0, 0, 0, 0, 4096, 32767, 0);
        add_row(1, 0, 0, 0, 639, -4096, -32768, 0);
        add_row(1, 0, 0, 0, 4095, -8192, 0, 0);
        add_row(0, 0, 5, 0, 0, 0, 0, 0);
        add_row(1, 0, 0, 0, 10, 100, -1, 0);
        foreach (directed_rows[i]) send_item(directed_rows[i]);
        end_burst();

        // no direction at all: the zero divisor gives the largest distance
        set_camera(0, 0, 2 * ONE + 5, 0, 0, 0, 0, 0);
        add_row(0, 40, 2, 1, 0, 0, 0, 0);
        add_row(1, 0, 0, 0, 0, 0, 0, 0);
        add_row(1, 0, 0, 0, 4095, 8191, 32767, 0);
        for (int i = 12; i < directed_rows.size(); i++) send_item(directed_rows[i]);
        end_burst();

        // random phases with fresh camera settings
        for (int ph = 0; ph < 13; ph++)
        begin
            send_idle = (ph < 4) ? 29 : (ph < 8) ? 46 : 0;
            recv_idle = (ph < 4) ? 46 : (ph < 8) ? 29 : 0;
            case (ph)
                0: set_camera(1, 1, 0, 0, -131072, -131072, 131072, 131072);
                1: set_camera(4096, 4096, 4194303, 4194303, 131072, 131072, -131072, -131072);
                2: set_camera(8191, 8191, 32 * ONE, 32 * ONE, 0, 65536, -43254, 0);
                default: set_camera($urandom_range(1, 4096), $urandom_range(1, 4096),
                                    $urandom_range(0, 4194303), $urandom_range(0, 4194303),
                                    $urandom_range(0, 262143), $urandom_range(0, 262143),
                                    $urandom_range(0, 262143), $urandom_range(0, 262143));
            endcase
            if (ph == 9) hold_req = 1;
            repeat (100) send_item(random_item());
            end_burst();
        end

        repeat (700) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #80000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
